// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker of this block.
// Each macro expands to one labeled concurrent assertion on clk, held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/kme_pkg.sv -----
// Shared types, constants and helpers of the k-mismatch match extension block.
// Used by the controller, the datapath, the top level and the checker.
package kme_pkg;

    // Store geometry.
    localparam int MAX_LEN   = 4096;
    localparam int CHAR_BITS = 8;
    localparam int ADDR_W    = $clog2(MAX_LEN);
    localparam int LEN_W     = ADDR_W + 1;
    localparam int SUM_W     = LEN_W + 1;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = LEN_W;
    localparam int BUDGET_W   = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_EXTRA = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN_X = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN_Y = 2'd2;

    // Request codes.
    localparam logic [1:0] REQ_LOAD_X = 2'd0;
    localparam logic [1:0] REQ_LOAD_Y = 2'd1;
    localparam logic [1:0] REQ_EXTEND = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_COMPARE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic wr_x;
        logic wr_y;
        logic init;
        logic step;
        logic finish;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic go;
        logic stop;
    } sts_t;

    // Limit a configured length to the store depth.
    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
        logic [LEN_W-1:0] lim;
        lim = LEN_W'(MAX_LEN);
        return (v > lim) ? lim : v;
    endfunction

endpackage

// ----- sv/kme_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; contents are undefined until written.
module kme_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/kme_ctrl.sv -----
// Controller state machine of the match extension block.
// Depends on kme_pkg for the state, command and status types.
module kme_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [1:0]    req_type,
    input  kme_pkg::sts_t sts,
    output kme_pkg::cmd_t cmd,
    output logic          busy
);

    kme_pkg::state_t state_reg;
    kme_pkg::state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kme_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state: a query alternates bounds check and read with compare until a bound or the budget stops it.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            kme_pkg::ST_IDLE:
            begin
                if (start && (req_type == kme_pkg::REQ_EXTEND))
                begin
                    state_next = kme_pkg::ST_CHECK;
                end
            end
            kme_pkg::ST_CHECK:
            begin
                state_next = sts.go ? kme_pkg::ST_COMPARE : kme_pkg::ST_IDLE;
            end
            kme_pkg::ST_COMPARE:
            begin
                state_next = sts.stop ? kme_pkg::ST_IDLE : kme_pkg::ST_CHECK;
            end
            default:
            begin
                state_next = kme_pkg::ST_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            kme_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    unique case (req_type)
                        kme_pkg::REQ_LOAD_X: cmd.wr_x = 1'b1;
                        kme_pkg::REQ_LOAD_Y: cmd.wr_y = 1'b1;
                        kme_pkg::REQ_EXTEND: cmd.init = 1'b1;
                        default:             cmd      = '0;
                    endcase
                end
            end
            kme_pkg::ST_CHECK:
            begin
                cmd.finish = !sts.go;
            end
            kme_pkg::ST_COMPARE:
            begin
                cmd.finish = sts.stop;
                cmd.step   = !sts.stop;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- sv/kme_dp.sv -----
// Datapath of the match extension block: configuration registers, the two
// sequence stores, the position and mismatch counters and the result registers.
// Depends on kme_pkg and kme_ram.
module kme_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  kme_pkg::cmd_t                  cmd,
    output kme_pkg::sts_t                  sts,
    input  logic                           cfg_we,
    input  logic [kme_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kme_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [kme_pkg::ADDR_W-1:0]     load_pos,
    input  logic [kme_pkg::CHAR_BITS-1:0]  load_char,
    input  logic                           direction,
    input  logic [kme_pkg::ADDR_W-1:0]     a_start,
    input  logic [kme_pkg::ADDR_W-1:0]     b_start,
    input  logic [kme_pkg::LEN_W-1:0]      prior_len,
    output logic                           done,
    output logic [kme_pkg::ADDR_W-1:0]     a_index,
    output logic [kme_pkg::LEN_W-1:0]      extended_len
);

    logic [kme_pkg::BUDGET_W-1:0]  extra_reg;
    logic [kme_pkg::LEN_W-1:0]     len_x_reg;
    logic [kme_pkg::LEN_W-1:0]     len_y_reg;

    logic                          swap_reg;
    logic [kme_pkg::ADDR_W-1:0]    a_start_reg;
    logic [kme_pkg::ADDR_W-1:0]    b_start_reg;
    logic [kme_pkg::LEN_W-1:0]     reach_reg;
    logic [kme_pkg::LEN_W-1:0]     reach_next;
    logic [kme_pkg::BUDGET_W-1:0]  misses_reg;
    logic [kme_pkg::BUDGET_W-1:0]  misses_next;

    logic                          done_reg;
    logic [kme_pkg::ADDR_W-1:0]    a_index_reg;
    logic [kme_pkg::LEN_W-1:0]     ext_len_reg;

    logic [kme_pkg::LEN_W-1:0]     lim_a;
    logic [kme_pkg::LEN_W-1:0]     lim_b;
    logic [kme_pkg::SUM_W-1:0]     pos_a;
    logic [kme_pkg::SUM_W-1:0]     pos_b;
    logic [kme_pkg::ADDR_W-1:0]    raddr_x;
    logic [kme_pkg::ADDR_W-1:0]    raddr_y;
    logic [kme_pkg::CHAR_BITS-1:0] rdata_x;
    logic [kme_pkg::CHAR_BITS-1:0] rdata_y;
    logic                          mismatch;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            extra_reg <= '0;
            len_x_reg <= '0;
            len_y_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                kme_pkg::CFG_EXTRA: extra_reg <= cfg_data[kme_pkg::BUDGET_W-1:0];
                kme_pkg::CFG_LEN_X: len_x_reg <= cfg_data;
                kme_pkg::CFG_LEN_Y: len_y_reg <= cfg_data;
                default:            extra_reg <= extra_reg;
            endcase
        end
    end

    // Current positions in sequences a and b, and the lengths that bound them.
    always_comb
    begin
        lim_a = swap_reg ? kme_pkg::clamp_len(len_y_reg) : kme_pkg::clamp_len(len_x_reg);
        lim_b = swap_reg ? kme_pkg::clamp_len(len_x_reg) : kme_pkg::clamp_len(len_y_reg);
        pos_a = {2'b00, a_start_reg} + {1'b0, reach_reg};
        pos_b = {2'b00, b_start_reg} + {1'b0, reach_reg};
    end

    // Store X holds a unless swapped; the compare is symmetric.
    assign raddr_x = swap_reg ? pos_b[kme_pkg::ADDR_W-1:0] : pos_a[kme_pkg::ADDR_W-1:0];
    assign raddr_y = swap_reg ? pos_a[kme_pkg::ADDR_W-1:0] : pos_b[kme_pkg::ADDR_W-1:0];

    kme_ram #(
        .WIDTH (kme_pkg::CHAR_BITS),
        .DEPTH (kme_pkg::MAX_LEN)
    ) u_store_x (
        .clk   (clk),
        .we    (cmd.wr_x),
        .waddr (load_pos),
        .wdata (load_char),
        .raddr (raddr_x),
        .rdata (rdata_x)
    );

    kme_ram #(
        .WIDTH (kme_pkg::CHAR_BITS),
        .DEPTH (kme_pkg::MAX_LEN)
    ) u_store_y (
        .clk   (clk),
        .we    (cmd.wr_y),
        .waddr (load_pos),
        .wdata (load_char),
        .raddr (raddr_y),
        .rdata (rdata_y)
    );

    // Status: another pair can be compared, or this mismatch exhausts the budget.
    assign mismatch = (rdata_x != rdata_y);
    assign sts.go   = (extra_reg != '0) && (pos_a < {1'b0, lim_a}) && (pos_b < {1'b0, lim_b});
    assign sts.stop = mismatch && (misses_reg == extra_reg);

    // Crawl counters.
    always_comb
    begin
        reach_next  = reach_reg;
        misses_next = misses_reg;
        if (cmd.init)
        begin
            reach_next  = prior_len;
            misses_next = '0;
        end
        else if (cmd.step)
        begin
            reach_next  = reach_reg + kme_pkg::LEN_W'(1);
            misses_next = misses_reg + kme_pkg::BUDGET_W'(mismatch);
        end
    end

    // Query registers; payload only, no reset.
    always_ff @(posedge clk)
    begin
        reach_reg  <= reach_next;
        misses_reg <= misses_next;
        if (cmd.init)
        begin
            swap_reg    <= direction;
            a_start_reg <= a_start;
            b_start_reg <= b_start;
        end
        if (cmd.finish)
        begin
            a_index_reg <= a_start_reg;
            ext_len_reg <= reach_reg;
        end
    end

    // Result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
        end
    end

    assign done         = done_reg;
    assign a_index      = a_index_reg;
    assign extended_len = ext_len_reg;

endmodule

// ----- sv/k_mismatch_match_extend.sv -----
// Top level of the match extension block; depends on kme_pkg, kme_ctrl and kme_dp.
// Loads write one character at their accept edge and give no result; busy stays low.
// A query crawls over P pairs (at most 4096) from its accept edge, each a bounds check and
// store read in ST_CHECK, then a compare in ST_COMPARE, up to a bound or the mismatch that
// exhausts the budget. Busy falls as done rises, so the next item can go in that cycle.
// Reset clears control state and configuration; stores are not. The receiver cannot stall.
module k_mismatch_match_extend (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     req_type,
    input  logic [kme_pkg::ADDR_W-1:0]     load_pos,
    input  logic [kme_pkg::CHAR_BITS-1:0]  load_char,
    input  logic                           direction,
    input  logic [kme_pkg::ADDR_W-1:0]     a_start,
    input  logic [kme_pkg::ADDR_W-1:0]     b_start,
    input  logic [kme_pkg::LEN_W-1:0]      prior_len,
    output logic                           done,
    output logic [kme_pkg::ADDR_W-1:0]     a_index,
    output logic [kme_pkg::LEN_W-1:0]      extended_len,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [kme_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kme_pkg::CFG_DATA_W-1:0] cfg_data
);

    kme_pkg::cmd_t cmd;
    kme_pkg::sts_t sts;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    kme_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .sts      (sts),
        .cmd      (cmd),
        .busy     (busy)
    );

    kme_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .load_pos     (load_pos),
        .load_char    (load_char),
        .direction    (direction),
        .a_start      (a_start),
        .b_start      (b_start),
        .prior_len    (prior_len),
        .done         (done),
        .a_index      (a_index),
        .extended_len (extended_len)
    );

endmodule

// ----- sv/kme_checker.sv -----
// Port-level checker for the match extension block, bound to the top level.
// Depends on kme_pkg and assert_macros.svh.
`include "assert_macros.svh"

module kme_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] req_type,
    input logic       done
);

    logic acc_query;
    logic acc_load;

    assign acc_query = start && !busy && (req_type == kme_pkg::REQ_EXTEND);
    assign acc_load  = start && !busy &&
                       ((req_type == kme_pkg::REQ_LOAD_X) || (req_type == kme_pkg::REQ_LOAD_Y));

    // A result only follows a cycle in which a query was in progress.
    `ASSERT_SAME(a_done_after_busy, done, $past(busy), "done without a query in progress")
    // Each query gives a single one-cycle strobe.
    `ASSERT_NEXT(a_done_single, done, !done, "done held for more than one cycle")
    // An accepted query occupies the block and cannot answer at once.
    `ASSERT_NEXT(a_query_busy, acc_query, busy && !done, "query did not start")
    // A load completes in its accept cycle and gives no result.
    `ASSERT_NEXT(a_load_quiet, acc_load, !busy && !done, "load made the block busy")

endmodule

bind k_mismatch_match_extend kme_checker u_kme_checker (.*);
